FILE: design/sfc_pkg.sv
// Shared definitions for the sphere frustum cull block.
// Holds the configuration register index codes; no dependencies.
package sfc_pkg;

	typedef enum logic [2:0] {
		REG_CAMERA = 3'd0,
		REG_FRONT  = 3'd1,
		REG_TOP    = 3'd2,
		REG_BOTTOM = 3'd3,
		REG_RIGHT  = 3'd4,
		REG_LEFT   = 3'd5,
		REG_DEPTH  = 3'd6,
		REG_FOG    = 3'd7
	} cfg_reg_t;

	localparam int unsigned NUM_NORMALS = 5;

endpackage

FILE: design/sfc_regs.sv
// Configuration register file for the sphere frustum cull block.
// Depends on sfc_pkg for register index codes.
module sfc_regs import sfc_pkg::*; #(
	parameter int unsigned COORD_BITS  = 20,
	parameter int unsigned NORMAL_BITS = 16,
	parameter int unsigned DATA_BITS   = 60
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [2:0]                wr_index,
	input  logic [DATA_BITS-1:0]      wr_data,
	output logic [3*COORD_BITS-1:0]   camera_position,
	output logic [3*NORMAL_BITS-1:0]  normals [NUM_NORMALS],
	output logic [COORD_BITS-1:0]     near_dist,
	output logic [COORD_BITS-1:0]     far_dist,
	output logic                      fog_en,
	output logic [COORD_BITS-1:0]     fog_end
);

	logic [3*COORD_BITS-1:0]  camera_q;
	logic [3*NORMAL_BITS-1:0] normal_q [NUM_NORMALS];
	logic [2*COORD_BITS-1:0]  depth_q;
	logic [COORD_BITS:0]      fog_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_q <= '0;
			for (int i = 0; i < NUM_NORMALS; i++) normal_q[i] <= '0;
			depth_q <= '0;
			fog_q   <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_CAMERA: camera_q    <= wr_data[3*COORD_BITS-1:0];
				REG_FRONT:  normal_q[0] <= wr_data[3*NORMAL_BITS-1:0];
				REG_TOP:    normal_q[1] <= wr_data[3*NORMAL_BITS-1:0];
				REG_BOTTOM: normal_q[2] <= wr_data[3*NORMAL_BITS-1:0];
				REG_RIGHT:  normal_q[3] <= wr_data[3*NORMAL_BITS-1:0];
				REG_LEFT:   normal_q[4] <= wr_data[3*NORMAL_BITS-1:0];
				REG_DEPTH:  depth_q     <= wr_data[2*COORD_BITS-1:0];
				REG_FOG:    fog_q       <= wr_data[COORD_BITS:0];
				default:    camera_q    <= camera_q;
			endcase
		end
	end

	assign camera_position = camera_q;
	assign normals         = normal_q;
	assign near_dist       = depth_q[COORD_BITS-1:0];
	assign far_dist        = depth_q[2*COORD_BITS-1:COORD_BITS];
	assign fog_en          = fog_q[COORD_BITS];
	assign fog_end         = fog_q[COORD_BITS-1:0];

endmodule

FILE: design/sfc_dot3.sv
// Two-stage dot product of a camera-relative offset with one packed normal.
// Stage 2 registers three products, stage 3 registers their sum. No package use.
module sfc_dot3 #(
	parameter int unsigned COORD_BITS  = 20,
	parameter int unsigned NORMAL_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 en_s2,
	input  logic                                 en_s3,
	input  logic [3*(COORD_BITS+1)-1:0]          offset,
	input  logic [3*NORMAL_BITS-1:0]             normal,
	output logic signed [COORD_BITS+NORMAL_BITS+2:0] dot
);

	localparam int unsigned OW = COORD_BITS + 1;
	localparam int unsigned PW = OW + NORMAL_BITS;
	localparam int unsigned SW = PW + 2;

	logic signed [PW-1:0] prod_s2 [3];
	logic signed [SW-1:0] sum_s3;
	logic signed [SW-1:0] sum_next;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= $signed(offset[i*OW +: OW]) *
				              $signed(normal[i*NORMAL_BITS +: NORMAL_BITS]);
			end
		end
	end

	assign sum_next = SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2]);

	always_ff @(posedge clk) begin
		if (en_s3) sum_s3 <= sum_next;
	end

	assign dot = sum_s3;

endmodule

FILE: design/sphere_frustum_cull.sv
// Sphere frustum cull top level: stream ports, offset stage, dot lanes, plane tests.
// Depends on sfc_pkg, sfc_regs and sfc_dot3.
//
// Takes one bounding sphere per beat and returns one beat with a visible flag. The
// pipeline accepts a new sphere every cycle unless an output stall has filled all of
// camera offset, products, dot sums, and the output register fed by the near, far, fog
// and four side plane tests. Each stage advances independently, so a stall on the output
// holds all data in place and bubbles close up. Configuration writes are accepted every
// cycle and must only be issued while no sphere is in flight.
module sphere_frustum_cull import sfc_pkg::*; #(
	parameter int unsigned COORD_BITS  = 20,
	parameter int unsigned NORMAL_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// s_tdata: center_x, center_y, center_z, sphere_radius, zero pad
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((4*COORD_BITS-1+7)/8)*8-1:0] s_tdata,
	// m_tdata: visible, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [3*((COORD_BITS > NORMAL_BITS) ? COORD_BITS : NORMAL_BITS)-1:0] cfg_data
);

	localparam int unsigned CW  = COORD_BITS;
	localparam int unsigned RW  = COORD_BITS - 1;
	localparam int unsigned OW  = COORD_BITS + 1;
	localparam int unsigned NF  = NORMAL_BITS - 2;
	localparam int unsigned SW  = COORD_BITS + NORMAL_BITS + 3;
	localparam int unsigned WW  = SW + 1;
	localparam int unsigned DW  = 3 * ((COORD_BITS > NORMAL_BITS) ? COORD_BITS : NORMAL_BITS);

	logic [3*CW-1:0]          camera_position;
	logic [3*NORMAL_BITS-1:0] normals [NUM_NORMALS];
	logic [CW-1:0]            near_dist;
	logic [CW-1:0]            far_dist;
	logic                     fog_en;
	logic [CW-1:0]            fog_end;

	assign cfg_ready = 1'b1;

	sfc_regs #(
		.COORD_BITS (COORD_BITS),
		.NORMAL_BITS(NORMAL_BITS),
		.DATA_BITS  (DW)
	) u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (cfg_valid),
		.wr_index       (cfg_index),
		.wr_data        (cfg_data),
		.camera_position(camera_position),
		.normals        (normals),
		.near_dist      (near_dist),
		.far_dist       (far_dist),
		.fog_en         (fog_en),
		.fog_end        (fog_end)
	);

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4     = !v_s4 || m_tready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// stage 1: camera-relative offset
	logic [3*OW-1:0] offset_s1;
	logic [RW-1:0]   radius_s1, radius_s2, radius_s3;

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int i = 0; i < 3; i++) begin
				offset_s1[i*OW +: OW] <= OW'($signed(s_tdata[i*CW +: CW])) -
				                         OW'($signed(camera_position[i*CW +: CW]));
			end
			radius_s1 <= s_tdata[3*CW +: RW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) radius_s2 <= radius_s1;
		if (adv3) radius_s3 <= radius_s2;
	end

	// stages 2 and 3: dot lanes
	logic signed [SW-1:0] dot_s3 [NUM_NORMALS];

	for (genvar g = 0; g < NUM_NORMALS; g++) begin : g_lane
		sfc_dot3 #(
			.COORD_BITS (COORD_BITS),
			.NORMAL_BITS(NORMAL_BITS)
		) u_dot (
			.clk   (clk),
			.en_s2 (adv2),
			.en_s3 (adv3),
			.offset(offset_s1),
			.normal(normals[g]),
			.dot   (dot_s3[g])
		);
	end

	// plane tests at common scale
	logic signed [WW-1:0] z_w, r_w, near_w, far_w, fog_w;
	logic signed [WW-1:0] side_w [4];
	logic                 cull_depth, cull_side, visible_next;

	assign z_w    = WW'(dot_s3[0]);
	assign r_w    = $signed({{(WW-RW-NF){1'b0}}, radius_s3, {NF{1'b0}}});
	assign near_w = $signed({{(WW-CW-NF){1'b0}}, near_dist, {NF{1'b0}}});
	assign far_w  = $signed({{(WW-CW-NF){1'b0}}, far_dist, {NF{1'b0}}});
	assign fog_w  = $signed({{(WW-CW-NF){1'b0}}, fog_end, {NF{1'b0}}});

	for (genvar g = 0; g < 4; g++) begin : g_side
		assign side_w[g] = WW'(dot_s3[g+1]);
	end

	assign cull_depth = (z_w + r_w < near_w) || (z_w - r_w > far_w) ||
	                    (fog_en && (z_w - r_w > fog_w));
	assign cull_side  = (side_w[0] < -r_w) || (side_w[1] < -r_w) ||
	                    (side_w[2] < -r_w) || (side_w[3] < -r_w);
	assign visible_next = !(cull_depth || cull_side);

	// stage 4: output register
	logic visible_s4;

	always_ff @(posedge clk) begin
		if (adv4) visible_s4 <= visible_next;
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {7'b0, visible_s4};

endmodule

FILE: design/sfc_checker.sv
// Port-level checker for the sphere frustum cull block, bound to the top level.
// Sees the handshake ports only; no package use.
module sfc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic cfg_valid,
	input logic cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("accepted sphere did not reach output in four cycles");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with a free output stage");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sphere_frustum_cull: streams bounding spheres under several
// frustum settings and checks each visible flag against an in-bench predictor.
// Depends on sfc_pkg and the sphere_frustum_cull RTL only.
module tb;
	import sfc_pkg::*;

	localparam int CB = 20;
	localparam int NB = 16;
	localparam int NF = NB - 2;
	localparam int PHASE_SPHERES = 180;

	typedef struct {
		logic [CB-1:0] cx;
		logic [CB-1:0] cy;
		logic [CB-1:0] cz;
		logic [CB-2:0] radius;
	} sphere_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [79:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = REG_CAMERA;
	logic [3*CB-1:0] cfg_data = '0;

	logic [3*CB-1:0] view_regs [8] = '{default: '0};
	logic [3*CB-1:0] phase_regs [8] = '{default: '0};
	sphere_t spheres_pending [$];
	bit visible_due [$];
	sphere_t in_flight;
	bit want;
	int unsigned spheres_sent = 0;
	int unsigned verdicts_seen = 0;
	int unsigned errors = 0;
	int unsigned gap_left = 0;
	int unsigned send_calm = 0;
	int unsigned stall_left = 0;
	int unsigned recv_calm = 0;

	sphere_frustum_cull #(.COORD_BITS(CB), .NORMAL_BITS(NB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint plane_dot(longint ox, longint oy, longint oz,
			logic [3*NB-1:0] n);
		longint nx, ny, nz;
		nx = $signed(n[NB-1:0]);
		ny = $signed(n[2*NB-1:NB]);
		nz = $signed(n[3*NB-1:2*NB]);
		return ox * nx + oy * ny + oz * nz;
	endfunction

	function automatic bit sphere_visible(sphere_t s);
		longint ox, oy, oz, z, r, near_d, far_d, fog_end;
		ox = $signed(s.cx);
		oy = $signed(s.cy);
		oz = $signed(s.cz);
		ox = ox - $signed(view_regs[REG_CAMERA][CB-1:0]);
		oy = oy - $signed(view_regs[REG_CAMERA][2*CB-1:CB]);
		oz = oz - $signed(view_regs[REG_CAMERA][3*CB-1:2*CB]);
		r = longint'(s.radius) << NF;
		near_d = longint'(view_regs[REG_DEPTH][CB-1:0]) << NF;
		far_d = longint'(view_regs[REG_DEPTH][2*CB-1:CB]) << NF;
		fog_end = longint'(view_regs[REG_FOG][CB-1:0]) << NF;
		z = plane_dot(ox, oy, oz, view_regs[REG_FRONT][3*NB-1:0]);
		if (z + r < near_d || z - r > far_d || (view_regs[REG_FOG][CB] && z - r > fog_end))
			return 1'b0;
		if (plane_dot(ox, oy, oz, view_regs[REG_TOP][3*NB-1:0]) < -r ||
				plane_dot(ox, oy, oz, view_regs[REG_BOTTOM][3*NB-1:0]) < -r ||
				plane_dot(ox, oy, oz, view_regs[REG_RIGHT][3*NB-1:0]) < -r ||
				plane_dot(ox, oy, oz, view_regs[REG_LEFT][3*NB-1:0]) < -r)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned pick_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(16, 48);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	function automatic int jitter();
		return int'($urandom_range(0, 1024)) - 512;
	endfunction

	function automatic int spread(int span);
		return int'($urandom_range(0, 2 << span)) - (1 << span);
	endfunction

	function automatic logic [3*CB-1:0] normal_word(int nx, int ny, int nz, logic [11:0] junk);
		return {junk, nz[NB-1:0], ny[NB-1:0], nx[NB-1:0]};
	endfunction

	function automatic logic [3*CB-1:0] depth_word(int near_d, int far_d);
		return {20'($urandom), far_d[CB-1:0], near_d[CB-1:0]};
	endfunction

	function automatic logic [3*CB-1:0] fog_word(bit en, int fog_end);
		return {39'({$urandom, $urandom}), en, fog_end[CB-1:0]};
	endfunction

	function automatic sphere_t random_sphere();
		sphere_t s;
		int span;
		if ($urandom_range(0, 9) < 3) begin
			s.cx = 20'($urandom);
			s.cy = 20'($urandom);
			s.cz = 20'($urandom);
			s.radius = 19'($urandom);
		end else begin
			span = $urandom_range(6, 18);
			s.cx = view_regs[REG_CAMERA][CB-1:0] + 20'(spread(span));
			s.cy = view_regs[REG_CAMERA][2*CB-1:CB] + 20'(spread(span));
			s.cz = view_regs[REG_CAMERA][3*CB-1:2*CB] + 20'(spread(span));
			s.radius = 19'($urandom_range(0, (1 << span) - 1));
		end
		return s;
	endfunction

	task automatic add_sphere(int x, int y, int z, int r);
		sphere_t s;
		s.cx = x[CB-1:0];
		s.cy = y[CB-1:0];
		s.cz = z[CB-1:0];
		s.radius = r[CB-2:0];
		spheres_pending.push_back(s);
		spheres_sent++;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (verdicts_seen != spheres_sent);
	endtask

	task automatic program_regs();
		int w;
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= phase_regs[i];
			do @(posedge clk); while (!cfg_ready);
			case (cfg_reg_t'(i))
				REG_CAMERA: w = 3 * CB;
				REG_DEPTH: w = 2 * CB;
				REG_FOG: w = CB + 1;
				default: w = 3 * NB;
			endcase
			view_regs[i] = phase_regs[i] & ((60'd1 << w) - 60'd1);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic build_frustum();
		int f, a, b, dir;
		int comp [3];
		f = $urandom_range(0, 2);
		a = (f + 1) % 3;
		b = (f + 2) % 3;
		dir = $urandom_range(0, 1) ? 1 : -1;
		for (int i = 0; i < 3; i++)
			comp[i] = spread(17);
		phase_regs[REG_CAMERA] = {comp[2][CB-1:0], comp[1][CB-1:0], comp[0][CB-1:0]};
		for (int i = 0; i < 3; i++)
			comp[i] = jitter();
		comp[f] += dir * 16384;
		phase_regs[REG_FRONT] = normal_word(comp[0], comp[1], comp[2], 12'($urandom));
		for (int side = 0; side < 4; side++) begin
			for (int i = 0; i < 3; i++)
				comp[i] = jitter();
			comp[f] += dir * 11585;
			comp[side < 2 ? a : b] += (side % 2) ? -11585 : 11585;
			phase_regs[int'(REG_TOP) + side] =
				normal_word(comp[0], comp[1], comp[2], 12'($urandom));
		end
		a = $urandom_range(0, 4096);
		phase_regs[REG_DEPTH] = depth_word(a, a + int'($urandom_range(0, 1 << 18)));
		phase_regs[REG_FOG] = fog_word($urandom_range(0, 1), $urandom_range(0, 1 << 18));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				visible_due.push_back(sphere_visible(in_flight));
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (spheres_pending.size() != 0) begin
					in_flight = spheres_pending.pop_front();
					s_tdata <= {1'b0, in_flight.radius, in_flight.cz, in_flight.cy, in_flight.cx};
					s_tvalid <= 1'b1;
					gap_left = pick_wait(send_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (visible_due.size() == 0) begin
					$error("visible: no sphere outstanding, got %0b", m_tdata[0]);
					errors++;
				end else begin
					want = visible_due.pop_front();
					verdicts_seen++;
					if (m_tdata[0] !== want) begin
						$error("visible: expected %0b, got %0b", want, m_tdata[0]);
						errors++;
					end
				end
				stall_left = pick_wait(recv_calm);
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers never written: zero normals, near = far = 0
		add_sphere(0, 0, 0, 0);
		add_sphere(524287, 524287, 524287, 524287);
		add_sphere(-524288, -524288, -524288, 0);
		wait_idle();

		// axis frustum looking down +x, fog on
		phase_regs[REG_CAMERA] = '0;
		phase_regs[REG_FRONT] = normal_word(16384, 0, 0, 0);
		phase_regs[REG_TOP] = normal_word(0, -16384, 0, 0);
		phase_regs[REG_BOTTOM] = normal_word(0, 16384, 0, 0);
		phase_regs[REG_RIGHT] = normal_word(0, 0, -16384, 0);
		phase_regs[REG_LEFT] = normal_word(0, 0, 16384, 0);
		phase_regs[REG_DEPTH] = depth_word(256, 256000);
		phase_regs[REG_FOG] = fog_word(1'b1, 128000);
		program_regs();
		add_sphere(256, 0, 0, 0);
		add_sphere(255, 0, 0, 0);
		add_sphere(200, 0, 0, 56);
		add_sphere(200, 0, 0, 55);
		add_sphere(128005, 0, 0, 5);
		add_sphere(128005, 0, 0, 4);
		add_sphere(1000, 1000, 0, 1000);
		add_sphere(1000, 1001, 0, 1000);
		add_sphere(1000, -1000, 0, 1000);
		add_sphere(1000, -1001, 0, 1000);
		add_sphere(1000, 0, 1000, 1000);
		add_sphere(1000, 0, 1001, 1000);
		add_sphere(1000, 0, -1000, 1000);
		add_sphere(1000, 0, -1001, 1000);
		add_sphere(524287, 0, 0, 524287);
		add_sphere(-524288, -524288, -524288, 524287);
		wait_idle();

		// fog off: far plane decides
		phase_regs[REG_FOG] = fog_word(1'b0, 128000);
		program_regs();
		add_sphere(256010, 0, 0, 10);
		add_sphere(256010, 0, 0, 9);
		add_sphere(200000, 0, 0, 0);
		wait_idle();

		// near beyond far
		phase_regs[REG_DEPTH] = depth_word(1000, 500);
		program_regs();
		add_sphere(700, 0, 0, 0);
		add_sphere(700, 0, 0, 524287);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			for (int i = 0; i < 8; i++) begin
				if (p == 0)
					phase_regs[i] = '0;
				else if (p == 1)
					phase_regs[i] = '1;
				else if (p == 2)
					phase_regs[i] = 60'({$urandom, $urandom});
			end
			if (p > 2)
				build_frustum();
			program_regs();
			for (int k = 0; k < PHASE_SPHERES; k++) begin
				spheres_pending.push_back(random_sphere());
				spheres_sent++;
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
design/sfc_pkg.sv
design/sfc_regs.sv
design/sfc_dot3.sv
design/sphere_frustum_cull.sv
design/sfc_checker.sv
tb/tb.sv
